@@ hdl/dof_pkg.sv @@
// ----------------------------------------------------------------------------
// dof_pkg
// Shared sizes, codes and types of the depth offset feature engine.
// ----------------------------------------------------------------------------
package dof_pkg;

  // Frame store geometry
  localparam int MAX_ROWS   = 512;
  localparam int MAX_COLS   = 512;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int DEPTH_BITS = 16;

  // Field and register widths
  localparam int OFF_W      = 24;
  localparam int SIZE_W     = 10;
  localparam int FV_W       = 17;
  localparam int FV_LIMIT   = 65535;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int Q_W        = OFF_W + 1;

  // Divider: one quotient bit a stage, four offsets side by side
  localparam int DIV_STAGES = OFF_W;
  localparam int LANES      = 4;

  // Item kinds carried on tuser
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFF1_ROW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF1_COL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF2_ROW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF2_COL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNARY     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE   = 3'd7;

  // Lane order inside the divider
  localparam int LANE_R1 = 0;
  localparam int LANE_C1 = 1;
  localparam int LANE_R2 = 2;
  localparam int LANE_C2 = 3;

  // What travels with a query beside the quotients
  typedef struct packed {
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [DEPTH_BITS-1:0] z;
  } dof_side_t;

endpackage

@@ hdl/dof_ram.sv @@
// ----------------------------------------------------------------------------
// dof_ram
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
module dof_ram #(
  parameter int ADDR_W = 18,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/dof_div.sv @@
// ----------------------------------------------------------------------------
// dof_div
// Pipelined restoring divider: four offsets divided by the reference depth,
// one quotient bit a stage, sign restored in a final stage.
// ----------------------------------------------------------------------------
module dof_div import dof_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  dof_side_t              in_side,
  input  logic [LANES-1:0]       in_neg,
  input  logic [LANES-1:0][OFF_W-1:0] in_mag,
  output logic                   out_valid,
  output dof_side_t              out_side,
  output logic [LANES-1:0][Q_W-1:0] out_quot,
  output logic                   busy
);

  logic [DIV_STAGES:0]                        vld;
  dof_side_t                                  side [DIV_STAGES+1];
  logic [DIV_STAGES:0][LANES-1:0]             neg;
  logic [DIV_STAGES:0][LANES-1:0][DEPTH_BITS-1:0] rem;
  logic [DIV_STAGES:0][LANES-1:0][OFF_W-1:0]  dq;
  logic [DIV_STAGES-1:0][LANES-1:0][DEPTH_BITS-1:0] rem_next;
  logic [DIV_STAGES-1:0][LANES-1:0][OFF_W-1:0]  dq_next;

  // Stage 0 is the input
  assign vld[0]  = in_valid;
  assign side[0] = in_side;
  assign neg[0]  = in_neg;
  assign rem[0]  = '0;
  assign dq[0]   = in_mag;

  // Shift one dividend bit into the remainder, subtract when it fits
  always_comb begin
    logic [DEPTH_BITS:0] sh;
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < LANES; l++) begin
        sh = {rem[s][l], dq[s][l][OFF_W-1]};
        if (sh >= {1'b0, side[s].z}) begin
          sh = sh - {1'b0, side[s].z};
          dq_next[s][l] = {dq[s][l][OFF_W-2:0], 1'b1};
        end else begin
          dq_next[s][l] = {dq[s][l][OFF_W-2:0], 1'b0};
        end
        rem_next[s][l] = sh[DEPTH_BITS-1:0];
      end
    end
  end

  // Advance the stages together
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[DIV_STAGES:1] <= '0;
    end else if (adv) begin
      vld[DIV_STAGES:1] <= vld[DIV_STAGES-1:0];
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        side[s+1] <= side[s];
        neg[s+1]  <= neg[s];
        rem[s+1]  <= rem_next[s];
        dq[s+1]   <= dq_next[s];
      end
    end
  end

  // Restore the sign: quotient truncates toward zero
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side <= side[DIV_STAGES];
      for (int l = 0; l < LANES; l++) begin
        out_quot[l] <= neg[DIV_STAGES][l] ? -{1'b0, dq[DIV_STAGES][l]}
                                          :  {1'b0, dq[DIV_STAGES][l]};
      end
    end
  end

  assign busy = (|vld) | out_valid;

endmodule

@@ hdl/dof_probe.sv @@
// ----------------------------------------------------------------------------
// dof_probe
// Probe position: reference plus quotient per axis, frame bounds check and
// store address, registered.
// ----------------------------------------------------------------------------
module dof_probe import dof_pkg::*; (
  input  logic              clk,
  input  logic              adv,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  input  logic [Q_W-1:0]    q_row,
  input  logic [Q_W-1:0]    q_col,
  input  logic [SIZE_W-1:0] height,
  input  logic [SIZE_W-1:0] width,
  output logic [ADDR_W-1:0] addr,
  output logic              in_frame
);

  logic signed [Q_W:0] r;
  logic signed [Q_W:0] c;
  logic [SIZE_W-1:0]   h;
  logic [SIZE_W-1:0]   w;

  // Effective frame is clipped to the store
  assign h = (height > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : height;
  assign w = (width  > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : width;

  assign r = $signed({{(Q_W+1-ROW_W){1'b0}}, row}) + $signed({q_row[Q_W-1], q_row});
  assign c = $signed({{(Q_W+1-COL_W){1'b0}}, col}) + $signed({q_col[Q_W-1], q_col});

  // Register the address and whether the probe lands in the frame
  always_ff @(posedge clk) begin
    if (adv) begin
      addr     <= {r[ROW_W-1:0], c[COL_W-1:0]};
      in_frame <= !r[Q_W] && !c[Q_W]
                  && (r < $signed({{(Q_W+1-SIZE_W){1'b0}}, h}))
                  && (c < $signed({{(Q_W+1-SIZE_W){1'b0}}, w}));
    end
  end

endmodule

@@ hdl/depth_offset_feature.sv @@
// ----------------------------------------------------------------------------
// depth_offset_feature
// Depth comparison feature engine: frame store, offset divider, two probes.
// ----------------------------------------------------------------------------
// A query word is taken every cycle while the output does not stall, and its
// result word passes the reference read on the edge that takes it, then 24
// divider stages of one quotient bit each, the sign stage, the probe address
// stage, the probe read and the result register. A pixel write word is
// stored at once when taken, but is held off while any query is still in
// the pipeline, so that each query's probes read the frame as it stood when
// it was taken. The frame store is kept in three copies, one each for the
// reference and two probe reads. Any stall at the output freezes the whole
// pipeline.
module depth_offset_feature import dof_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [39:0]           s_tdata,   // pix_row[8:0], pix_col[17:9], depth_in[33:18]
  input  logic                  s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // feature_value[16:0]
  output logic                  m_tuser,   // zero_depth_error
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [OFF_W-1:0]      off1_row, off1_col, off2_row, off2_col;
  logic                  unary_mode;
  logic [SIZE_W-1:0]     frame_height, frame_width;
  logic [DEPTH_BITS-1:0] outside_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      off1_row      <= '0;
      off1_col      <= '0;
      off2_row      <= '0;
      off2_col      <= '0;
      unary_mode    <= 1'b0;
      frame_height  <= SIZE_W'(MAX_ROWS);
      frame_width   <= SIZE_W'(MAX_COLS);
      outside_depth <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFF1_ROW: off1_row      <= cfg_data[OFF_W-1:0];
        REG_OFF1_COL: off1_col      <= cfg_data[OFF_W-1:0];
        REG_OFF2_ROW: off2_row      <= cfg_data[OFF_W-1:0];
        REG_OFF2_COL: off2_col      <= cfg_data[OFF_W-1:0];
        REG_UNARY:    unary_mode    <= cfg_data[0];
        REG_HEIGHT:   frame_height  <= cfg_data[SIZE_W-1:0];
        REG_WIDTH:    frame_width   <= cfg_data[SIZE_W-1:0];
        REG_OUTSIDE:  outside_depth <= cfg_data[DEPTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input word fields
  logic [ROW_W-1:0]      in_row;
  logic [COL_W-1:0]      in_col;
  logic [DEPTH_BITS-1:0] in_depth;
  logic                  adv, busy, div_busy, take, wr_en;

  assign in_row   = s_tdata[8:0];
  assign in_col   = s_tdata[17:9];
  assign in_depth = s_tdata[33:18];

  // Whole pipeline moves unless a finished result waits
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !(s_tuser == FUNC_WRITE && busy);
  assign take     = s_tvalid && s_tready;
  assign wr_en    = take && (s_tuser == FUNC_WRITE);

  // Stage A: reference read
  logic                  a_vld;
  logic [ROW_W-1:0]      a_row;
  logic [COL_W-1:0]      a_col;
  logic [DEPTH_BITS-1:0] z_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= take && (s_tuser == FUNC_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_row <= in_row;
      a_col <= in_col;
    end
  end

  dof_ram #(.ADDR_W(ADDR_W), .DATA_W(DEPTH_BITS)) u_ram_ref (
    .clk(clk), .we(wr_en), .waddr({in_row, in_col}), .wdata(in_depth),
    .re(adv), .raddr({in_row, in_col}), .rdata(z_rd)
  );

  // Divider input: split offsets into sign and magnitude
  dof_side_t                      div_in_side, d_side;
  logic [LANES-1:0]               div_neg;
  logic [LANES-1:0][OFF_W-1:0]    div_mag;
  logic [LANES-1:0][OFF_W-1:0]    offs;
  logic                           d_vld;
  logic [LANES-1:0][Q_W-1:0]      d_quot;

  assign offs[LANE_R1] = off1_row;
  assign offs[LANE_C1] = off1_col;
  assign offs[LANE_R2] = off2_row;
  assign offs[LANE_C2] = off2_col;

  always_comb begin
    div_in_side.row = a_row;
    div_in_side.col = a_col;
    div_in_side.z   = z_rd;
    for (int l = 0; l < LANES; l++) begin
      div_neg[l] = offs[l][OFF_W-1];
      div_mag[l] = offs[l][OFF_W-1] ? -offs[l] : offs[l];
    end
  end

  dof_div u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(a_vld), .in_side(div_in_side), .in_neg(div_neg), .in_mag(div_mag),
    .out_valid(d_vld), .out_side(d_side), .out_quot(d_quot), .busy(div_busy)
  );

  // Stage P: probe addresses
  logic                  p_vld, p_in1, p_in2;
  dof_side_t             p_side;
  logic [ADDR_W-1:0]     p_addr1, p_addr2;

  dof_probe u_probe1 (
    .clk(clk), .adv(adv), .row(d_side.row), .col(d_side.col),
    .q_row(d_quot[LANE_R1]), .q_col(d_quot[LANE_C1]),
    .height(frame_height), .width(frame_width), .addr(p_addr1), .in_frame(p_in1)
  );

  dof_probe u_probe2 (
    .clk(clk), .adv(adv), .row(d_side.row), .col(d_side.col),
    .q_row(d_quot[LANE_R2]), .q_col(d_quot[LANE_C2]),
    .height(frame_height), .width(frame_width), .addr(p_addr2), .in_frame(p_in2)
  );

  // Stage R: probe reads
  logic                  r_vld, r_in1, r_in2;
  dof_side_t             r_side;
  logic [DEPTH_BITS-1:0] p1_rd, p2_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      r_vld <= 1'b0;
    end else if (adv) begin
      p_vld <= d_vld;
      r_vld <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_side <= d_side;
      r_side <= p_side;
      r_in1  <= p_in1;
      r_in2  <= p_in2;
    end
  end

  dof_ram #(.ADDR_W(ADDR_W), .DATA_W(DEPTH_BITS)) u_ram_p1 (
    .clk(clk), .we(wr_en), .waddr({in_row, in_col}), .wdata(in_depth),
    .re(adv), .raddr(p_addr1), .rdata(p1_rd)
  );

  dof_ram #(.ADDR_W(ADDR_W), .DATA_W(DEPTH_BITS)) u_ram_p2 (
    .clk(clk), .we(wr_en), .waddr({in_row, in_col}), .wdata(in_depth),
    .re(adv), .raddr(p_addr2), .rdata(p2_rd)
  );

  assign busy = a_vld | div_busy | p_vld | r_vld;

  // Result: difference, saturated, zero reference reports an error
  localparam int DIFF_W = DEPTH_BITS + 2;
  logic [DEPTH_BITS-1:0]    p1_val, p2_val;
  logic signed [DIFF_W-1:0] diff;
  logic [FV_W-1:0]          fv;

  always_comb begin
    p1_val = r_in1 ? p1_rd : outside_depth;
    if (unary_mode) begin
      p2_val = r_side.z;
    end else begin
      p2_val = r_in2 ? p2_rd : outside_depth;
    end
    diff = $signed({2'b00, p1_val}) - $signed({2'b00, p2_val});
    if (diff > $signed(DIFF_W'(FV_LIMIT))) begin
      fv = FV_W'(FV_LIMIT);
    end else if (diff < -$signed(DIFF_W'(FV_LIMIT))) begin
      fv = -FV_W'(FV_LIMIT);
    end else begin
      fv = diff[FV_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser <= (r_side.z == '0);
      m_tdata <= (r_side.z == '0) ? '0 : {{(24-FV_W){1'b0}}, fv};
    end
  end

endmodule

@@ hdl/dof_checker.sv @@
// ----------------------------------------------------------------------------
// dof_checker
// Port-level checks of the depth offset feature engine, bound to the top.
// ----------------------------------------------------------------------------
module dof_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  // A waiting result word stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word dropped or changed under stall");

  // An error word carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 24'd0)
    else $error("zero depth error with nonzero value");

  // Value stays within the saturation limits, padding clear
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[16:0] != 17'h10000 && m_tdata[23:17] == 7'd0)
    else $error("feature value out of range");

  // Nothing is shown straight after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result word valid after reset");

endmodule

bind depth_offset_feature dof_checker u_dof_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);
